### src/mfb_pkg.sv
package mfb_pkg;

  localparam int PIXELS_PER_BYTE       = 8;
  localparam int SCREEN_WIDTH_DEFAULT  = 128;
  localparam int SCREEN_HEIGHT_DEFAULT = 64;

  // request operation codes
  localparam logic OP_PAINT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic        [11:0] rect_width;
    logic        [11:0] rect_height;
    logic               paint_foreground;
    logic        [9:0]  byte_address;
  } mfb_req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       fully_clipped;
  } mfb_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLIP,
    S_INIT,
    S_RUN,
    S_FLUSH,
    S_READ,
    S_DONE
  } mfb_state_e;

  typedef struct packed {
    logic clip;
    logic init;
    logic step;
  } mfb_walk_ctl_t;

  typedef struct packed {
    logic empty;
    logic last;
  } mfb_walk_sts_t;

endpackage

### src/mfb_ram.sv
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/mfb_walk.sv
module mfb_walk import mfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT,
  localparam int BPR      = (SCREEN_WIDTH + PIXELS_PER_BYTE - 1) / PIXELS_PER_BYTE,
  localparam int FB_BYTES = BPR * SCREEN_HEIGHT,
  localparam int AW       = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfb_walk_ctl_t      ctl_i,
  input  logic signed [11:0] origin_x_i,
  input  logic signed [11:0] origin_y_i,
  input  logic        [11:0] rect_width_i,
  input  logic        [11:0] rect_height_i,
  output mfb_walk_sts_t      sts_o,
  output logic [AW-1:0]      addr_o,
  output logic [7:0]         mask_o
);

  localparam int XW  = $clog2(SCREEN_WIDTH + 1);
  localparam int YW  = $clog2(SCREEN_HEIGHT + 1);
  localparam int BCW = (BPR > 1) ? $clog2(BPR) : 1;

  // clamp a 14-bit signed coordinate to [0, hi]
  function automatic logic [12:0] clamp14(input logic signed [13:0] v, input logic [12:0] hi);
    logic [12:0] r;
    if (v[13]) begin
      r = '0;
    end else if (v[12:0] > hi) begin
      r = hi;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  logic [XW-1:0]  x0_q, x1_q, xl;
  logic [YW-1:0]  y0_q, y1_q, row_q;
  logic [BCW-1:0] bx0_q, bx1_q, b_q, bx0_c, bx1_c;
  logic [7:0]     lmask_q, rmask_q;
  logic [AW-1:0]  base_q;
  logic signed [13:0] ox_ext, oy_ext, x_end, y_end;

  assign ox_ext = {{2{origin_x_i[11]}}, origin_x_i};
  assign oy_ext = {{2{origin_y_i[11]}}, origin_y_i};
  assign x_end  = ox_ext + $signed({2'b00, rect_width_i});
  assign y_end  = oy_ext + $signed({2'b00, rect_height_i});

  assign xl    = x1_q - XW'(1);
  assign bx0_c = BCW'(x0_q >> 3);
  assign bx1_c = BCW'(xl >> 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q <= '0;
      x1_q <= '0;
      y0_q <= '0;
      y1_q <= '0;
    end else if (ctl_i.clip) begin
      x0_q <= XW'(clamp14(ox_ext, 13'(SCREEN_WIDTH)));
      x1_q <= XW'(clamp14(x_end, 13'(SCREEN_WIDTH)));
      y0_q <= YW'(clamp14(oy_ext, 13'(SCREEN_HEIGHT)));
      y1_q <= YW'(clamp14(y_end, 13'(SCREEN_HEIGHT)));
    end
  end

  // byte walker: one byte address and mask per step, row base kept by addition
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      bx0_q   <= bx0_c;
      bx1_q   <= bx1_c;
      b_q     <= bx0_c;
      lmask_q <= 8'hFF >> x0_q[2:0];
      rmask_q <= 8'hFF << (3'd7 - xl[2:0]);
      row_q   <= y0_q;
      base_q  <= AW'(y0_q * BPR);
    end else if (ctl_i.step) begin
      if (b_q == bx1_q) begin
        b_q    <= bx0_q;
        row_q  <= row_q + YW'(1);
        base_q <= base_q + AW'(BPR);
      end else begin
        b_q <= b_q + BCW'(1);
      end
    end
  end

  assign sts_o.empty = (x0_q >= x1_q) || (y0_q >= y1_q);
  assign sts_o.last  = (b_q == bx1_q) && (row_q == y1_q - YW'(1));
  assign addr_o      = base_q + AW'(b_q);
  assign mask_o      = ((b_q == bx0_q) ? lmask_q : 8'hFF) & ((b_q == bx1_q) ? rmask_q : 8'hFF);

endmodule

### src/mono_framebuffer_rect_fill_top.sv
// Channel   | Ports                        | Handshake
// ----------+------------------------------+-------------------------------------
// request   | req_i (mfb_req_t)            | taken when start && !busy
// result    | result_o (mfb_res_t)         | valid for one cycle with done_o
// config    | cfg_we_i, cfg_wdata_i        | written whenever cfg_we_i is high
//
// After reset a clearing pass zeroes the framebuffer, one byte a cycle, over
// BYTES_PER_ROW * SCREEN_HEIGHT bytes (1024 at default size), busy high.
// Read request: done_o follows acceptance through the S_READ and S_DONE states.
// Paint request: S_CLIP, S_INIT, one S_RUN per byte of the clipped rectangle
// (one read-modify-write byte per cycle via the byte walker and the RAM with
// one port each way), S_FLUSH, S_DONE; a fully clipped paint skips to S_DONE.
// busy stays high until the cycle after done_o; results cannot be stalled.
module mono_framebuffer_rect_fill_top import mfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  mfb_req_t req_i,
  output logic     done_o,
  output mfb_res_t result_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  localparam int BPR      = (SCREEN_WIDTH + PIXELS_PER_BYTE - 1) / PIXELS_PER_BYTE;
  localparam int FB_BYTES = BPR * SCREEN_HEIGHT;
  localparam int AW       = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;

  mfb_state_e    state_q, state_d;
  mfb_req_t      req_q;
  logic          fg_black_q;     // foreground_is_black
  logic          set_q;          // paint sets bits rather than clearing them
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    wr_mask_q;
  logic [AW-1:0] clr_q;
  logic          res_clip_q, res_read_q, res_aok_q;

  mfb_walk_ctl_t walk_ctl;
  mfb_walk_sts_t walk_sts;
  logic [AW-1:0] walk_addr;
  logic [7:0]    walk_mask;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(FB_BYTES - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_d = (req_i.operation == OP_READ) ? S_READ : S_CLIP;
        end
      end
      S_CLIP:  state_d = S_INIT;
      S_INIT:  state_d = walk_sts.empty ? S_DONE : S_RUN;
      S_RUN:   if (walk_sts.last) state_d = S_FLUSH;
      S_FLUSH: state_d = S_DONE;
      S_READ:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs to the walker and the RAM
  // ---------------------------------------------------------------------------
  always_comb begin
    walk_ctl  = '0;
    ram_re    = 1'b0;
    ram_raddr = walk_addr;
    ram_we    = wr_pend_q;
    ram_waddr = wr_addr_q;
    ram_wdata = set_q ? (ram_rdata | wr_mask_q) : (ram_rdata & ~wr_mask_q);
    done_o    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_CLIP: walk_ctl.clip = 1'b1;
      S_INIT: walk_ctl.init = !walk_sts.empty;
      S_RUN: begin
        ram_re        = 1'b1;
        walk_ctl.step = 1'b1;
      end
      S_READ: begin
        ram_re    = res_aok_q;
        ram_raddr = AW'(req_q.byte_address);
      end
      S_DONE:  done_o = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      fg_black_q <= 1'b1;
      wr_pend_q  <= 1'b0;
      res_clip_q <= 1'b0;
      res_read_q <= 1'b0;
      res_aok_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= (state_q == S_RUN);
      if (cfg_we_i) begin
        fg_black_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (accept) begin
        res_clip_q <= 1'b0;
        res_read_q <= (req_i.operation == OP_READ);
        res_aok_q  <= (32'(req_i.byte_address) < 32'(FB_BYTES));
      end else if (state_q == S_INIT) begin
        res_clip_q <= walk_sts.empty;
      end
    end
  end

  // request and write-back pipe payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      set_q <= (req_i.paint_foreground == fg_black_q);
    end
    if (state_q == S_RUN) begin
      wr_addr_q <= walk_addr;
      wr_mask_q <= walk_mask;
    end
  end

  assign result_o.read_byte     = (res_read_q && res_aok_q) ? ram_rdata : 8'h00;
  assign result_o.fully_clipped = res_clip_q && !res_read_q;

  // ---------------------------------------------------------------------------
  // Units
  // ---------------------------------------------------------------------------
  mfb_walk #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (walk_ctl),
    .origin_x_i    (req_q.origin_x),
    .origin_y_i    (req_q.origin_y),
    .rect_width_i  (req_q.rect_width),
    .rect_height_i (req_q.rect_height),
    .sts_o         (walk_sts),
    .addr_o        (walk_addr),
    .mask_o        (walk_mask)
  );

  mfb_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after a request was taken");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR) || (state_q == S_RUN) || (state_q == S_FLUSH))
    else $error("framebuffer written outside clearing or painting");

  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.fully_clipped && (result_o.read_byte != 8'h00)))
    else $error("result carries both read data and clipped flag");

endmodule
